// ===== hw/rtl/bmia_pkg.sv =====
// Shared types, codes and constants of the bitmap inode and block allocator.
package bmia_pkg;

   localparam int FIELD_W      = 14;
   localparam int CMD_W        = 2;
   localparam int STATUS_W     = 2;
   localparam int MAP_BITS_DEF = 8192;
   localparam int WORD_MAX     = 64;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 48;
   localparam int RSP_PAD_W    = RSP_DATA_W - 3 * FIELD_W;
   localparam int CSR_INDEX_W  = 1;
   localparam int COUNT_CAP    = (1 << FIELD_W) - 1;

   localparam logic [FIELD_W-1:0] COUNT_RESET = FIELD_W'(8192);

   localparam logic [CSR_INDEX_W-1:0] REG_INODE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_INODE = 2'd0,
      CMD_ALLOC_BLOCK = 2'd1,
      CMD_FREE_INODE  = 2'd2,
      CMD_FREE_BLOCK  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_RANGE    = 2'd2,
      STAT_NOT_USED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LOOKUP,
      S_EXEC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic chunk_inc;
      logic rd_scan;
      logic rd_num;
      logic set_full;
      logic set_range;
      logic commit;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic range_bad;
      logic chunk_free;
      logic chunk_last;
      logic word_beyond;
      logic rsp_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/bmia_ctrl.sv =====
// Controller state machine sequencing scan, lookup, commit and result hand-off.
module bmia_ctrl
   import bmia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_free,
   output logic        req_tready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = req_free ? S_LOOKUP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.chunk_free) begin
               if (stat.word_beyond) begin
                  cmd.set_full = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  cmd.rd_scan = 1'b1;
                  state_in    = S_EXEC;
               end
            end else if (stat.chunk_last) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.chunk_inc = 1'b1;
            end
         end
         S_LOOKUP: begin
            if (stat.range_bad) begin
               cmd.set_range = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_num = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== hw/rtl/bmia_datapath.sv =====
// Datapath: map memory, word-full summary, counters, count registers and result register.
module bmia_datapath
   import bmia_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_wdata,
   input  ctl_cmd_type            cmd,
   output dp_stat_type            stat
);

   localparam int WORD_W = (MAP_BITS < WORD_MAX) ? (1 << $clog2(MAP_BITS)) : WORD_MAX;
   localparam int WB_W   = $clog2(WORD_W);
   localparam int WORDS  = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ROWS   = 1 << WA_W;
   localparam int SC_W   = (ROWS < WORD_MAX) ? ROWS : WORD_MAX;
   localparam int SCB_W  = $clog2(SC_W);
   localparam int NCHUNK = ROWS / SC_W;
   localparam int CC_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int NCH2   = 1 << CC_W;
   localparam int SI_W   = CC_W + SCB_W;
   localparam int CMP_W  = ((SI_W + WB_W > FIELD_W) ? (SI_W + WB_W) : FIELD_W) + 1;
   localparam int MEM_AW = WA_W + 1;
   localparam int CAP    = (MAP_BITS < COUNT_CAP) ? MAP_BITS : COUNT_CAP;
   localparam logic [FIELD_W-1:0] CAP_V = FIELD_W'(CAP);

   logic [WORD_W-1:0]           map_mem_ff [1 << MEM_AW];
   logic [WORD_W-1:0]           rd_data_ff;
   logic [NCH2-1:0][SC_W-1:0]   sum_ff [2];
   logic [NCH2-1:0][SC_W-1:0]   sum_in [2];
   logic [FIELD_W-1:0]          inode_cnt_ff;
   logic [FIELD_W-1:0]          block_cnt_ff;
   logic [FIELD_W-1:0]          inodes_used_ff;
   logic [FIELD_W-1:0]          inodes_used_in;
   logic [FIELD_W-1:0]          blocks_used_ff;
   logic [FIELD_W-1:0]          blocks_used_in;
   cmd_type                     cmd_ff;
   logic [FIELD_W-1:0]          num_ff;
   logic [CC_W-1:0]             chunk_ff;
   logic [CC_W-1:0]             chunk_in;
   logic [SI_W-1:0]             word_ff;
   logic [SI_W-1:0]             word_in;
   logic [WB_W-1:0]             bitpos_ff;
   logic [WB_W-1:0]             bitpos_in;
   status_type                  status_ff;
   status_type                  status_in;
   logic [FIELD_W-1:0]          alloc_ff;
   logic [FIELD_W-1:0]          alloc_in;
   logic [MEM_AW-1:0]           clr_ff;
   logic [MEM_AW-1:0]           clr_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff;
   logic [STATUS_W-1:0]         rsp_user_ff;

   logic [FIELD_W-1:0]          ni_eff;
   logic [FIELD_W-1:0]          nb_eff;
   logic [FIELD_W-1:0]          n_sel;
   logic [FIELD_W-1:0]          free_i;
   logic [FIELD_W-1:0]          free_b;
   logic                        map_sel;
   logic                        is_free;
   logic [FIELD_W-1:0]          num_idx;
   logic [CMP_W-1:0]            num_ext;
   logic [WA_W-1:0]             num_row;
   logic [WB_W-1:0]             num_bit;
   logic [SC_W-1:0]             chunk_vec;
   logic [SCB_W-1:0]            chunk_pos;
   logic                        chunk_free;
   logic [SI_W-1:0]             scan_word;
   logic [CMP_W-1:0]            scan_base;
   logic [WB_W-1:0]             word_pos;
   logic                        word_has_zero;
   logic [CMP_W-1:0]            found_idx;
   logic                        alloc_ok;
   logic [WORD_W-1:0]           bit_mask;
   logic                        free_hit;
   logic [WORD_W-1:0]           new_word;
   logic                        commit_ok;
   logic                        rd_en;
   logic [MEM_AW-1:0]           rd_addr;
   logic                        wr_en;
   logic [MEM_AW-1:0]           wr_addr;
   logic [WORD_W-1:0]           wr_data;

   assign ni_eff  = (inode_cnt_ff > CAP_V) ? CAP_V : inode_cnt_ff;
   assign nb_eff  = (block_cnt_ff > CAP_V) ? CAP_V : block_cnt_ff;
   assign map_sel = cmd_ff[0];
   assign is_free = cmd_ff[1];
   assign n_sel   = map_sel ? nb_eff : ni_eff;
   assign free_i  = (ni_eff > inodes_used_ff) ? (ni_eff - inodes_used_ff) : '0;
   assign free_b  = (nb_eff > blocks_used_ff) ? (nb_eff - blocks_used_ff) : '0;

   assign num_idx = num_ff - {{(FIELD_W-1){1'b0}}, ~map_sel};
   assign num_ext = CMP_W'(num_idx);
   assign num_row = num_ext[WB_W +: WA_W];
   assign num_bit = num_ext[WB_W-1:0];

   assign chunk_vec = sum_ff[map_sel][chunk_ff];

   always_comb begin
      chunk_pos  = '0;
      chunk_free = 1'b0;
      for (int i = SC_W - 1; i >= 0; i--) begin
         if (!chunk_vec[i]) begin
            chunk_pos  = SCB_W'(i);
            chunk_free = 1'b1;
         end
      end
   end

   assign scan_word = {chunk_ff, chunk_pos};
   assign scan_base = CMP_W'({scan_word, {WB_W{1'b0}}});

   always_comb begin
      word_pos      = '0;
      word_has_zero = 1'b0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!rd_data_ff[i]) begin
            word_pos      = WB_W'(i);
            word_has_zero = 1'b1;
         end
      end
   end

   assign found_idx = CMP_W'({word_ff, word_pos});
   assign alloc_ok  = word_has_zero && (found_idx < CMP_W'(n_sel));
   assign bit_mask  = WORD_W'(1) << (is_free ? bitpos_ff : word_pos);
   assign free_hit  = |(rd_data_ff & bit_mask);
   assign new_word  = is_free ? (rd_data_ff & ~bit_mask) : (rd_data_ff | bit_mask);
   assign commit_ok = is_free ? free_hit : alloc_ok;

   assign rd_en   = cmd.rd_scan | cmd.rd_num;
   assign rd_addr = {map_sel, (cmd.rd_scan ? scan_word[WA_W-1:0] : num_row)};
   assign wr_en   = cmd.clear_step | (cmd.commit & commit_ok);
   assign wr_addr = cmd.clear_step ? clr_ff : {map_sel, word_ff[WA_W-1:0]};
   assign wr_data = cmd.clear_step ? '0 : new_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem_ff[rd_addr];
      end
   end

   always_comb begin
      sum_in         = sum_ff;
      inodes_used_in = inodes_used_ff;
      blocks_used_in = blocks_used_ff;
      chunk_in       = chunk_ff;
      word_in        = word_ff;
      bitpos_in      = bitpos_ff;
      status_in      = status_ff;
      alloc_in       = alloc_ff;
      clr_in         = cmd.clear_step ? (clr_ff + MEM_AW'(1)) : clr_ff;
      if (cmd.load_req) begin
         chunk_in  = '0;
         status_in = STAT_OK;
         alloc_in  = '0;
      end
      if (cmd.chunk_inc) begin
         chunk_in = chunk_ff + CC_W'(1);
      end
      if (cmd.rd_scan) begin
         word_in = scan_word;
      end
      if (cmd.rd_num) begin
         word_in   = SI_W'(num_row);
         bitpos_in = num_bit;
      end
      if (cmd.set_full) begin
         status_in = STAT_FULL;
      end
      if (cmd.set_range) begin
         status_in = STAT_RANGE;
      end
      if (cmd.commit) begin
         if (!commit_ok) begin
            status_in = is_free ? STAT_NOT_USED : STAT_FULL;
         end else begin
            sum_in[map_sel][word_ff[SI_W-1:SCB_W]][word_ff[SCB_W-1:0]] = &new_word;
            if (is_free) begin
               if (map_sel) begin
                  if (blocks_used_ff != '0) begin
                     blocks_used_in = blocks_used_ff - FIELD_W'(1);
                  end
               end else if (inodes_used_ff != '0) begin
                  inodes_used_in = inodes_used_ff - FIELD_W'(1);
               end
            end else begin
               if (map_sel) begin
                  blocks_used_in = blocks_used_ff + FIELD_W'(1);
                  alloc_in       = found_idx[FIELD_W-1:0];
               end else begin
                  inodes_used_in = inodes_used_ff + FIELD_W'(1);
                  alloc_in       = found_idx[FIELD_W-1:0] + FIELD_W'(1);
               end
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff         <= '{default: '0};
         inodes_used_ff <= '0;
         blocks_used_ff <= '0;
         inode_cnt_ff   <= COUNT_RESET;
         block_cnt_ff   <= COUNT_RESET;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         sum_ff         <= sum_in;
         inodes_used_ff <= inodes_used_in;
         blocks_used_ff <= blocks_used_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_INODE_COUNT: inode_cnt_ff <= csr_wdata;
               REG_BLOCK_COUNT: block_cnt_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff  <= chunk_in;
      word_ff   <= word_in;
      bitpos_ff <= bitpos_in;
      status_ff <= status_in;
      alloc_ff  <= alloc_in;
      if (cmd.load_req) begin
         cmd_ff <= cmd_type'(req_tuser);
         num_ff <= req_tdata[FIELD_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, free_b, free_i, alloc_ff};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign stat.clear_last  = &clr_ff;
   assign stat.range_bad   = map_sel ? (num_ff >= nb_eff) : ((num_ff == '0) || (num_ff > ni_eff));
   assign stat.chunk_free  = chunk_free;
   assign stat.chunk_last  = (chunk_ff == CC_W'(NCHUNK - 1));
   assign stat.word_beyond = (scan_base >= CMP_W'(n_sel));
   assign stat.rsp_free    = !rsp_valid_ff || rsp_tready;

endmodule

// ===== hw/rtl/bitmap_inode_block_allocator_core.sv =====
// Top level of the bitmap first-fit inode and block allocator.
//
//   channel   direction   fields (lowest bit up)
//   req_*     in          tuser: cmd[1:0]; tdata: number[13:0], zero pad[15:14]
//   rsp_*     out         tuser: status[1:0]; tdata: allocated[13:0],
//                         inodes_free[27:14], free_blocks[41:28], zero pad[47:42]
//   csr_*     in          we, index (0 inode_count, 1 block_count), wdata[13:0]
//
// Allocate: k = 1 to MAP_BITS/4096 scan steps of 64 word-full flags each, then a
// commit step unless the map is full; free: a lookup step, then a commit step unless
// out of range. Each transaction does at most one read and one write-back of the map.
// After reset a clearing pass writes all 2 * 2^ceil(log2(MAP_BITS/64)) map rows
// (256 at 8192 bits); no request is taken until it ends.
// A stalled result holds; the next transaction is accepted meanwhile and its result waits.
module bitmap_inode_block_allocator_core
   import bmia_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // number[13:0], pad
   input  logic [CMD_W-1:0]       req_tuser,   // cmd[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // allocated, inodes_free, free_blocks, pad
   output logic [STATUS_W-1:0]    rsp_tuser,   // status[1:0]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_wdata
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   bmia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_free   (req_tuser[1]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bmia_datapath #(
      .MAP_BITS (MAP_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== hw/rtl/bmia_checker.sv =====
// Port-level assertions for the allocator core and the bind that attaches them.
module bmia_checker
   import bmia_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in progress");

   a_no_number_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_FULL || rsp_tuser == STAT_RANGE ||
                     rsp_tuser == STAT_NOT_USED) |-> rsp_tdata[FIELD_W-1:0] == '0)
      else $error("number reported with a failing status");

endmodule

bind bitmap_inode_block_allocator_core bmia_checker u_bmia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/bmia_alloc_checker.sv =====
`timescale 1ns / 100ps
// Checker: predicts each allocator response from the accepted requests and compares it.
module bmia_alloc_checker
   import bmia_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // number[13:0], pad
   input  logic [CMD_W-1:0]       req_tuser,   // cmd[1:0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // allocated, inodes_free, free_blocks, pad
   input  logic [STATUS_W-1:0]    rsp_tuser,   // status[1:0]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   localparam int INODE_MAP = 0;
   localparam int BLOCK_MAP = 1;

   typedef struct packed {
      logic [FIELD_W-1:0] allocated;
      status_type         status;
      logic [FIELD_W-1:0] inodes_free;
      logic [FIELD_W-1:0] free_blocks;
   } alloc_result_type;

   bit                 map_bits [2][MAP_BITS_DEF];
   int                 used [2];
   logic [FIELD_W-1:0] count_reg [2];
   alloc_result_type   pending_results [$];

   function automatic int capped(input logic [FIELD_W-1:0] c);
      return (c > MAP_BITS_DEF) ? MAP_BITS_DEF : int'(c);
   endfunction

   function automatic logic [FIELD_W-1:0] free_left(input int m);
      int lim;
      lim = capped(count_reg[m]);
      return (lim > used[m]) ? FIELD_W'(lim - used[m]) : '0;
   endfunction

   function automatic int first_clear(input int m, input int lim);
      for (int i = 0; i < lim; i++)
         if (!map_bits[m][i])
            return i;
      return -1;
   endfunction

   function automatic alloc_result_type apply_command(input cmd_type c,
                                                      input logic [FIELD_W-1:0] n);
      alloc_result_type r;
      int               lim_i;
      int               lim_b;
      int               idx;
      lim_i = capped(count_reg[INODE_MAP]);
      lim_b = capped(count_reg[BLOCK_MAP]);
      r.allocated = '0;
      r.status = STAT_OK;
      case (c)
         CMD_ALLOC_INODE: begin
            idx = first_clear(INODE_MAP, lim_i);
            if (idx < 0) begin
               r.status = STAT_FULL;
            end else begin
               map_bits[INODE_MAP][idx] = 1'b1;
               used[INODE_MAP]++;
               r.allocated = FIELD_W'(idx + 1);
            end
         end
         CMD_ALLOC_BLOCK: begin
            idx = first_clear(BLOCK_MAP, lim_b);
            if (idx < 0) begin
               r.status = STAT_FULL;
            end else begin
               map_bits[BLOCK_MAP][idx] = 1'b1;
               used[BLOCK_MAP]++;
               r.allocated = FIELD_W'(idx);
            end
         end
         CMD_FREE_INODE: begin
            if (n == 0 || n > lim_i) begin
               r.status = STAT_RANGE;
            end else if (!map_bits[INODE_MAP][n - 1]) begin
               r.status = STAT_NOT_USED;
            end else begin
               map_bits[INODE_MAP][n - 1] = 1'b0;
               if (used[INODE_MAP] > 0)
                  used[INODE_MAP]--;
            end
         end
         default: begin
            if (n >= lim_b) begin
               r.status = STAT_RANGE;
            end else if (!map_bits[BLOCK_MAP][n]) begin
               r.status = STAT_NOT_USED;
            end else begin
               map_bits[BLOCK_MAP][n] = 1'b0;
               if (used[BLOCK_MAP] > 0)
                  used[BLOCK_MAP]--;
            end
         end
      endcase
      r.inodes_free = free_left(INODE_MAP);
      r.free_blocks = free_left(BLOCK_MAP);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         foreach (map_bits[m, i])
            map_bits[m][i] = 1'b0;
         used[INODE_MAP] = 0;
         used[BLOCK_MAP] = 0;
         count_reg[INODE_MAP] = COUNT_RESET;
         count_reg[BLOCK_MAP] = COUNT_RESET;
         pending_results.delete();
         fail_count = 0;
         outstanding = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_INODE_COUNT)
               count_reg[INODE_MAP] = csr_wdata;
            else
               count_reg[BLOCK_MAP] = csr_wdata;
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_command(cmd_type'(req_tuser),
                                                    req_tdata[FIELD_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[FIELD_W-1:0] !== want.allocated) begin
                  $error("allocated: expected %0d, actual %0d",
                         want.allocated, rsp_tdata[FIELD_W-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[2*FIELD_W-1:FIELD_W] !== want.inodes_free) begin
                  $error("inodes_free: expected %0d, actual %0d",
                         want.inodes_free, rsp_tdata[2*FIELD_W-1:FIELD_W]);
                  fail_count++;
               end
               if (rsp_tdata[3*FIELD_W-1:2*FIELD_W] !== want.free_blocks) begin
                  $error("free_blocks: expected %0d, actual %0d",
                         want.free_blocks, rsp_tdata[3*FIELD_W-1:2*FIELD_W]);
                  fail_count++;
               end
            end
         end
         outstanding = pending_results.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives requests and count writes into the allocator and gives the verdict.
module tb_top;
   import bmia_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 86;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // number[13:0], pad
   logic [CMD_W-1:0]       req_tuser;   // cmd[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // allocated, inodes_free, free_blocks, pad
   logic [STATUS_W-1:0]    rsp_tuser;   // status[1:0]
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [FIELD_W-1:0]     csr_wdata;

   int                 fail_count;
   int                 outstanding;
   int                 cycle_count;
   bit                 quiet_phase;
   logic [FIELD_W-1:0] inode_limit;
   logic [FIELD_W-1:0] block_limit;

   logic [FIELD_W-1:0] inode_plan [PHASES] = '{14'd8, 14'd16383, 14'd1, 14'd40,
                                               14'd0, 14'd8192, 14'd20, 14'd5};
   logic [FIELD_W-1:0] block_plan [PHASES] = '{14'd8, 14'd8192, 14'd3, 14'd25,
                                               14'd12, 14'd0, 14'd16383, 14'd64};

   bitmap_inode_block_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bmia_alloc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         stall = quiet_phase ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready))
            @(posedge clock);
      end
   end

   task automatic send_command(input cmd_type c, input logic [FIELD_W-1:0] n);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= REQ_DATA_W'(n);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // hold requests until every response has come back
   task automatic await_drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_count(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [FIELD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_INODE_COUNT)
         inode_limit = value;
      else
         block_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int                 roll;
      int                 span;
      cmd_type            c;
      logic [FIELD_W-1:0] n;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_ALLOC_INODE;
      csr_we      = 1'b0;
      csr_index   = REG_INODE_COUNT;
      csr_wdata   = '0;
      quiet_phase = 1'b0;
      inode_limit = COUNT_RESET;
      block_limit = COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // full-size maps straight out of reset
      send_command(CMD_ALLOC_INODE, 14'd16383);
      send_command(CMD_ALLOC_BLOCK, 14'd0);
      send_command(CMD_ALLOC_BLOCK, 14'd5);
      send_command(CMD_FREE_INODE, 14'd0);
      send_command(CMD_FREE_INODE, 14'd8193);
      send_command(CMD_FREE_INODE, 14'd16383);
      send_command(CMD_FREE_BLOCK, 14'd8192);
      send_command(CMD_FREE_BLOCK, 14'd16383);
      send_command(CMD_FREE_BLOCK, 14'd7);
      send_command(CMD_FREE_INODE, 14'd2);
      send_command(CMD_FREE_INODE, 14'd1);
      send_command(CMD_FREE_INODE, 14'd1);
      send_command(CMD_FREE_BLOCK, 14'd0);
      send_command(CMD_ALLOC_BLOCK, 14'd0);
      send_command(CMD_FREE_INODE, 14'd8192);
      await_drain();

      // empty maps
      write_count(REG_INODE_COUNT, 14'd0);
      write_count(REG_BLOCK_COUNT, 14'd0);
      send_command(CMD_ALLOC_INODE, 14'd0);
      send_command(CMD_ALLOC_BLOCK, 14'd0);
      send_command(CMD_FREE_INODE, 14'd1);
      send_command(CMD_FREE_BLOCK, 14'd0);
      await_drain();

      // tiny inode map, block count above the map size
      write_count(REG_INODE_COUNT, 14'd3);
      write_count(REG_BLOCK_COUNT, 14'd16383);
      repeat (4) send_command(CMD_ALLOC_INODE, 14'd0);
      send_command(CMD_ALLOC_BLOCK, 14'd0);
      await_drain();

      // shrink below the inodes in use
      write_count(REG_INODE_COUNT, 14'd1);
      send_command(CMD_FREE_INODE, 14'd3);
      send_command(CMD_ALLOC_INODE, 14'd0);
      await_drain();

      for (int p = 0; p < PHASES; p++) begin
         write_count(REG_INODE_COUNT, inode_plan[p]);
         write_count(REG_BLOCK_COUNT, block_plan[p]);
         quiet_phase = (p % 3 == 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               c = (roll < 22) ? CMD_ALLOC_INODE : CMD_ALLOC_BLOCK;
               n = FIELD_W'($urandom);
            end else if (roll < 90) begin
               c = (roll < 67) ? CMD_FREE_INODE : CMD_FREE_BLOCK;
               span = (c == CMD_FREE_INODE) ? int'(inode_limit) : int'(block_limit);
               if (span > 48)
                  span = 48;
               n = FIELD_W'($urandom_range(0, span + 2));
            end else begin
               c = cmd_type'($urandom_range(0, 3));
               n = FIELD_W'($urandom);
            end
            send_command(c, n);
            if (p == 2 && k == PHASE_ITEMS / 2)
               await_drain();
         end
         await_drain();
      end

      quiet_phase = 1'b0;
      repeat (16) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
